### rtl/gpn_pkg.sv
// Shared types, command codes and register indexes for the gamepad navigator.
// Used by gpn_front, gpn_queue, gpn_back and the top level.
package gpn_pkg;

  localparam int unsigned MaxCmds = 3;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_AXIS    = 2'd3;

  localparam logic [2:0] AXIS_LX   = 3'd0;
  localparam logic [2:0] AXIS_LY   = 3'd1;
  localparam logic [2:0] AXIS_LTRG = 3'd2;
  localparam logic [2:0] AXIS_RTRG = 3'd3;
  localparam logic [2:0] AXIS_RX   = 3'd4;
  localparam logic [2:0] AXIS_RY   = 3'd5;

  localparam logic [2:0] REG_DEADZONE  = 3'd0;
  localparam logic [2:0] REG_TRIG_THR  = 3'd1;
  localparam logic [2:0] REG_FIRST_INT = 3'd2;
  localparam logic [2:0] REG_SHORT_INT = 3'd3;
  localparam logic [2:0] REG_INT_STEP  = 3'd4;
  localparam logic [2:0] REG_TRIG_PER  = 3'd5;

  localparam logic [14:0] RST_DEADZONE  = 15'd8000;
  localparam logic [14:0] RST_TRIG_THR  = 15'd16000;
  localparam logic [7:0]  RST_FIRST_INT = 8'd25;
  localparam logic [7:0]  RST_SHORT_INT = 8'd4;
  localparam logic [7:0]  RST_INT_STEP  = 8'd4;
  localparam logic [7:0]  RST_TRIG_PER  = 8'd6;

  localparam logic [3:0] DIR_NONE     = 4'd0;
  localparam logic [3:0] DIR_LS_UP    = 4'd5;
  localparam logic [3:0] DIR_LS_DOWN  = 4'd6;
  localparam logic [3:0] DIR_LS_LEFT  = 4'd7;
  localparam logic [3:0] DIR_LS_RIGHT = 4'd8;
  localparam logic [3:0] DIR_LAST     = 4'd8;

  localparam logic [3:0] BTN_BACK       = 4'd4;
  localparam logic [3:0] BTN_START      = 4'd5;
  localparam logic [3:0] BTN_DPAD_UP    = 4'd8;
  localparam logic [3:0] BTN_DPAD_RIGHT = 4'd11;

  localparam logic [4:0] CMD_START        = 5'd4;
  localparam logic [4:0] CMD_SELECT       = 5'd5;
  localparam logic [4:0] CMD_DIR_OFFSET   = 5'd7;
  localparam logic [4:0] CMD_RSTICK_LEFT  = 5'd16;
  localparam logic [4:0] CMD_RSTICK_RIGHT = 5'd17;
  localparam logic [4:0] CMD_TRIG_LEFT    = 5'd18;
  localparam logic [4:0] CMD_TRIG_RIGHT   = 5'd19;
  localparam logic [4:0] CMD_VOL_UP       = 5'd20;
  localparam logic [4:0] CMD_VOL_DOWN     = 5'd21;

  typedef struct packed {
    logic [1:0]           cnt;
    logic [2:0][4:0]      cmd;
  } bundle_t;

  function automatic logic [4:0] press_cmd(input logic [3:0] btn);
    logic [4:0] c;
    unique case (btn)
      BTN_BACK:  c = CMD_SELECT;
      BTN_START: c = CMD_START;
      default:   c = {1'b0, btn};
    endcase
    return c;
  endfunction

endpackage

### rtl/gpn_front.sv
// Front part: configuration registers, hold and repeat state, and event
// classification into a bundle of up to three commands. Uses gpn_pkg.
module gpn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [14:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [3:0]           button_i,
  input  logic [2:0]           axis_i,
  input  logic signed [15:0]   axis_value_i,
  input  logic                 app_active_i,
  input  logic                 space_i,
  output logic                 push_o,
  output gpn_pkg::bundle_t     bundle_o
);

  logic [14:0] deadzone_q, trig_thr_q;
  logic [7:0]  first_int_q, short_int_q, int_step_q, trig_per_q;

  logic [3:0] held_q, held_d;
  logic [7:0] ticks_q, ticks_d;
  logic [7:0] interval_q, interval_d;
  logic [5:0] flags_q, flags_d;
  logic [1:0] trig_q, trig_d;
  logic [7:0] tl_q, tl_d;
  logic [7:0] tr_q, tr_d;

  logic accept;
  logic signed [16:0] v_ext, dz_pos, dz_neg, thr_ext;
  logic below, above, trig_above;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign v_ext      = {axis_value_i[15], axis_value_i};
  assign dz_pos     = {2'b00, deadzone_q};
  assign dz_neg     = -dz_pos;
  assign thr_ext    = {2'b00, trig_thr_q};
  assign below      = v_ext < dz_neg;
  assign above      = v_ext > dz_pos;
  assign trig_above = v_ext > thr_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q  <= gpn_pkg::RST_DEADZONE;
      trig_thr_q  <= gpn_pkg::RST_TRIG_THR;
      first_int_q <= gpn_pkg::RST_FIRST_INT;
      short_int_q <= gpn_pkg::RST_SHORT_INT;
      int_step_q  <= gpn_pkg::RST_INT_STEP;
      trig_per_q  <= gpn_pkg::RST_TRIG_PER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpn_pkg::REG_DEADZONE:  deadzone_q  <= cfg_wdata_i;
        gpn_pkg::REG_TRIG_THR:  trig_thr_q  <= cfg_wdata_i;
        gpn_pkg::REG_FIRST_INT: first_int_q <= cfg_wdata_i[7:0];
        gpn_pkg::REG_SHORT_INT: short_int_q <= cfg_wdata_i[7:0];
        gpn_pkg::REG_INT_STEP:  int_step_q  <= cfg_wdata_i[7:0];
        gpn_pkg::REG_TRIG_PER:  trig_per_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= gpn_pkg::DIR_NONE;
      ticks_q    <= '0;
      interval_q <= gpn_pkg::RST_FIRST_INT;
      flags_q    <= '0;
      trig_q     <= '0;
      tl_q       <= '0;
      tr_q       <= '0;
    end else if (accept) begin
      held_q     <= held_d;
      ticks_q    <= ticks_d;
      interval_q <= interval_d;
      flags_q    <= flags_d;
      trig_q     <= trig_d;
      tl_q       <= tl_d;
      tr_q       <= tr_d;
    end
  end

  always_comb begin
    logic [1:0] n;
    logic [8:0] t9;
    logic [2:0] nb;
    logic [3:0] ndir, pdir;
    n          = 2'd0;
    t9         = '0;
    nb         = 3'd0;
    ndir       = gpn_pkg::DIR_LS_LEFT;
    pdir       = gpn_pkg::DIR_LS_RIGHT;
    held_d     = held_q;
    ticks_d    = ticks_q;
    interval_d = interval_q;
    flags_d    = flags_q;
    trig_d     = trig_q;
    tl_d       = tl_q;
    tr_d       = tr_q;
    bundle_o   = '0;

    if (!app_active_i) begin
      held_d = gpn_pkg::DIR_NONE;
      trig_d = '0;
    end else begin
      unique case (action_i)
        gpn_pkg::ACT_TICK: begin
          if (held_q != gpn_pkg::DIR_NONE) begin
            t9 = {1'b0, ticks_q} + 9'd1;
            if (t9 >= {1'b0, interval_q}) begin
              ticks_d = '0;
              if ({1'b0, interval_q} >= ({1'b0, short_int_q} + {1'b0, int_step_q})) begin
                interval_d = interval_q - int_step_q;
              end else begin
                interval_d = short_int_q;
              end
              if (held_q <= gpn_pkg::DIR_LAST) begin
                bundle_o.cmd[n] = {1'b0, held_q} + gpn_pkg::CMD_DIR_OFFSET;
                n = n + 2'd1;
              end
            end else begin
              ticks_d = t9[7:0];
            end
          end
          if (trig_q[0]) begin
            t9 = {1'b0, tl_q} + 9'd1;
            if (t9 >= {1'b0, trig_per_q}) begin
              tl_d = '0;
              bundle_o.cmd[n] = gpn_pkg::CMD_TRIG_LEFT;
              n = n + 2'd1;
            end else begin
              tl_d = t9[7:0];
            end
          end
          if (trig_q[1]) begin
            t9 = {1'b0, tr_q} + 9'd1;
            if (t9 >= {1'b0, trig_per_q}) begin
              tr_d = '0;
              bundle_o.cmd[n] = gpn_pkg::CMD_TRIG_RIGHT;
              n = n + 2'd1;
            end else begin
              tr_d = t9[7:0];
            end
          end
        end
        gpn_pkg::ACT_PRESS: begin
          if (!button_i[3]) begin
            bundle_o.cmd[0] = gpn_pkg::press_cmd(button_i);
            n = 2'd1;
          end else if (button_i <= gpn_pkg::BTN_DPAD_RIGHT) begin
            held_d          = button_i - 4'd7;
            ticks_d         = '0;
            interval_d      = first_int_q;
            bundle_o.cmd[0] = {1'b0, button_i};
            n = 2'd1;
          end
        end
        gpn_pkg::ACT_RELEASE: begin
          if (button_i >= gpn_pkg::BTN_DPAD_UP && button_i <= gpn_pkg::BTN_DPAD_RIGHT &&
              held_q == button_i - 4'd7) begin
            held_d = gpn_pkg::DIR_NONE;
          end
        end
        gpn_pkg::ACT_AXIS: begin
          unique case (axis_i) inside
            gpn_pkg::AXIS_LX, gpn_pkg::AXIS_LY: begin
              if (axis_i == gpn_pkg::AXIS_LX) begin
                nb   = 3'd0;
                ndir = gpn_pkg::DIR_LS_LEFT;
                pdir = gpn_pkg::DIR_LS_RIGHT;
              end else begin
                nb   = 3'd2;
                ndir = gpn_pkg::DIR_LS_UP;
                pdir = gpn_pkg::DIR_LS_DOWN;
              end
              if (below) begin
                if (!flags_q[nb]) begin
                  flags_d[nb]     = 1'b1;
                  held_d          = ndir;
                  ticks_d         = '0;
                  interval_d      = first_int_q;
                  bundle_o.cmd[0] = {1'b0, ndir} + gpn_pkg::CMD_DIR_OFFSET;
                  n = 2'd1;
                end
              end else if (above) begin
                if (!flags_q[nb + 3'd1]) begin
                  flags_d[nb + 3'd1] = 1'b1;
                  held_d             = pdir;
                  ticks_d            = '0;
                  interval_d         = first_int_q;
                  bundle_o.cmd[0]    = {1'b0, pdir} + gpn_pkg::CMD_DIR_OFFSET;
                  n = 2'd1;
                end
              end else begin
                flags_d[nb]        = 1'b0;
                flags_d[nb + 3'd1] = 1'b0;
                if (held_q == ndir || held_q == pdir) begin
                  held_d = gpn_pkg::DIR_NONE;
                end
              end
            end
            gpn_pkg::AXIS_LTRG: begin
              if (trig_above) begin
                if (!trig_q[0]) begin
                  trig_d[0]       = 1'b1;
                  tl_d            = '0;
                  bundle_o.cmd[0] = gpn_pkg::CMD_TRIG_LEFT;
                  n = 2'd1;
                end
              end else begin
                trig_d[0] = 1'b0;
              end
            end
            gpn_pkg::AXIS_RTRG: begin
              if (trig_above) begin
                if (!trig_q[1]) begin
                  trig_d[1]       = 1'b1;
                  tr_d            = '0;
                  bundle_o.cmd[0] = gpn_pkg::CMD_TRIG_RIGHT;
                  n = 2'd1;
                end
              end else begin
                trig_d[1] = 1'b0;
              end
            end
            gpn_pkg::AXIS_RX: begin
              if (below) begin
                if (!flags_q[4]) begin
                  flags_d[4]      = 1'b1;
                  bundle_o.cmd[0] = gpn_pkg::CMD_RSTICK_LEFT;
                  n = 2'd1;
                end
              end else if (above) begin
                if (!flags_q[5]) begin
                  flags_d[5]      = 1'b1;
                  bundle_o.cmd[0] = gpn_pkg::CMD_RSTICK_RIGHT;
                  n = 2'd1;
                end
              end else begin
                flags_d[5:4] = 2'b00;
              end
            end
            gpn_pkg::AXIS_RY: begin
              if (below) begin
                bundle_o.cmd[0] = gpn_pkg::CMD_VOL_UP;
                n = 2'd1;
              end else if (above) begin
                bundle_o.cmd[0] = gpn_pkg::CMD_VOL_DOWN;
                n = 2'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    bundle_o.cnt = n;
  end

  assign push_o = accept & (bundle_o.cnt != 2'd0);

endmodule

### rtl/gpn_queue.sv
// Two-entry queue of command bundles between the front and back parts.
// Uses gpn_pkg::bundle_t.
module gpn_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gpn_pkg::bundle_t  bundle_i,
  output logic              space_o,
  input  logic              pop_i,
  output logic              avail_o,
  output gpn_pkg::bundle_t  bundle_o
);

  gpn_pkg::bundle_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign space_o  = count_q != 2'd2;
  assign avail_o  = count_q != 2'd0;
  assign bundle_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/gpn_back.sv
// Back part: holds one command bundle and hands out its commands one per
// item, marking the final one. Uses gpn_pkg::bundle_t.
module gpn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  gpn_pkg::bundle_t  bundle_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        command_o,
  output logic              last_o
);

  logic            busy_q;
  logic [1:0]      idx_q, cnt_q;
  logic [2:0][4:0] cmd_q;
  logic            fire;

  assign out_valid_o = busy_q;
  assign command_o   = cmd_q[idx_q];
  assign last_o      = idx_q == (cnt_q - 2'd1);
  assign fire        = busy_q & out_ready_i;
  assign pop_o       = avail_i & (~busy_q | (fire & last_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= bundle_i.cmd;
      cnt_q <= bundle_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

### rtl/gamepad_auto_repeat_navigator.sv
// Top level of the gamepad navigator: front classifier, bundle queue and
// command serializer. Depends on gpn_pkg, gpn_front, gpn_queue, gpn_back.
//
// Input channel (in_valid_i/in_ready_o) takes one event item per cycle while
// the queue has room: tick, button press, button release or axis sample.
// Each item yields zero to three commands, grouped in the front and queued.
// Output channel (out_valid_o/out_ready_i) gives one command item per cycle
// to a ready receiver; last_o marks the final command of its input item.
// An accepted item goes into the bundle queue, then the back part, before its
// first command shows. Throughput: one item per cycle while each yields at
// most one command and the receiver is ready; an item with k commands holds
// the output for k commands. The two-entry bundle queue sets how far input
// runs ahead of output. A stalled receiver holds the current command; the
// input keeps accepting until the queue fills, then in_ready_o drops.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) land at the edge.
// Reset clears all holds and flags, empties the queue and restores defaults.
module gamepad_auto_repeat_navigator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [14:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [3:0]          button_i,
  input  logic [2:0]          axis_i,
  input  logic signed [15:0]  axis_value_i,
  input  logic                app_active_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          command_o,
  output logic                last_o
);

  gpn_pkg::bundle_t front_bundle, queue_bundle;
  logic push, space, pop, avail;

  gpn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .button_i     (button_i),
    .axis_i       (axis_i),
    .axis_value_i (axis_value_i),
    .app_active_i (app_active_i),
    .space_i      (space),
    .push_o       (push),
    .bundle_o     (front_bundle)
  );

  gpn_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (front_bundle),
    .space_o  (space),
    .pop_i    (pop),
    .avail_o  (avail),
    .bundle_o (queue_bundle)
  );

  gpn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .bundle_i    (queue_bundle),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o),
    .last_o      (last_o)
  );

endmodule

### dv/gamepad_auto_repeat_navigator_tb.sv
// Self-checking testbench for gamepad_auto_repeat_navigator: a directed table, then
// random hold, stick and trigger sequences under six register settings, checked against
// an in-bench model of the navigator. Depends on gpn_pkg and the RTL only.
`timescale 1ns / 100ps

module gamepad_auto_repeat_navigator_tb;
  import gpn_pkg::*;

  localparam int LIMIT_CYCLES   = 200000;
  localparam int PHASE_ITEMS    = 58;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int VAL_MIN        = -32768;
  localparam int VAL_MAX        = 32767;

  localparam logic [3:0] BTN_A         = 4'd0;
  localparam logic [3:0] BTN_BACK      = 4'd4;
  localparam logic [3:0] BTN_START     = 4'd5;
  localparam logic [3:0] BTN_RSHOULDER = 4'd7;
  localparam logic [3:0] BTN_DPAD_DOWN = 4'd9;
  localparam logic [3:0] BTN_RESERVED  = 4'd15;
  localparam logic [2:0] AXIS_UNUSED   = 3'd7;

  localparam int FLAG_LX     = 0;
  localparam int FLAG_LY     = 2;
  localparam int FLAG_RX_NEG = 4;
  localparam int FLAG_RX_POS = 5;

  typedef enum logic [4:0] {
    NAV_A, NAV_B, NAV_X, NAV_Y, NAV_START, NAV_SELECT, NAV_LSHOULDER, NAV_RSHOULDER,
    NAV_DPAD_UP, NAV_DPAD_DOWN, NAV_DPAD_LEFT, NAV_DPAD_RIGHT,
    NAV_LS_UP, NAV_LS_DOWN, NAV_LS_LEFT, NAV_LS_RIGHT, NAV_RS_LEFT, NAV_RS_RIGHT,
    NAV_TRIG_LEFT, NAV_TRIG_RIGHT, NAV_VOL_UP, NAV_VOL_DOWN
  } nav_cmd_e;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_mode_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         button;
    logic [2:0]         axis;
    logic signed [15:0] value;
    logic               active;
  } nav_event_t;

  typedef struct packed {
    logic [4:0] command;
    logic       last;
  } nav_result_t;

  typedef struct packed {
    nav_event_t ev;
    row_mode_e  mode;
    logic [4:0] typed_cmd;
  } nav_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [2:0]         cfg_idx_i    = '0;
  logic [14:0]        cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i     = '0;
  logic [3:0]         button_i     = '0;
  logic [2:0]         axis_i       = '0;
  logic signed [15:0] axis_value_i = '0;
  logic               app_active_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [4:0]         command_o;
  logic               last_o;

  // model configuration
  logic [14:0] cfg_deadzone = RST_DEADZONE;
  logic [14:0] cfg_trig_thr = RST_TRIG_THR;
  logic [7:0]  cfg_first    = RST_FIRST_INT;
  logic [7:0]  cfg_shortest = RST_SHORT_INT;
  logic [7:0]  cfg_step     = RST_INT_STEP;
  logic [7:0]  cfg_trig_per = RST_TRIG_PER;

  // model state
  logic [3:0] held_dir     = DIR_NONE;
  logic [7:0] rep_ticks    = '0;
  logic [7:0] rep_int      = RST_FIRST_INT;
  logic [5:0] stick_flags  = '0;
  logic [1:0] trig_flags   = '0;
  logic [7:0] trig_l_ticks = '0;
  logic [7:0] trig_r_ticks = '0;

  logic [4:0]  step_cmds [MaxCmds];
  int unsigned step_n;

  nav_result_t pending_cmds[$];
  nav_result_t rx_exp;
  nav_row_t    directed_rows[$];

  int  error_count      = 0;
  int  items_sent       = 0;
  int  cmds_checked     = 0;
  int  settings_applied = 0;
  int  cycle_count      = 0;
  int  burst_requests   = 0;
  int  burst_served     = 0;
  int  rx_hold          = 0;
  int  rx_wait          = 0;
  bit  tx_gaps          = 1'b1;
  bit  rx_gaps          = 1'b1;

  gamepad_auto_repeat_navigator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .button_i     (button_i),
    .axis_i       (axis_i),
    .axis_value_i (axis_value_i),
    .app_active_i (app_active_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d commands outstanding",
               cycle_count, pending_cmds.size());
      $display("gamepad_auto_repeat_navigator_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void emit_cmd(input logic [4:0] c);
    if (step_n < MaxCmds) begin
      step_cmds[step_n] = c;
      step_n++;
    end
  endfunction

  function automatic void start_hold(input logic [3:0] dir);
    held_dir  = dir;
    rep_ticks = '0;
    rep_int   = cfg_first;
  endfunction

  function automatic void left_stick(input int v, input int flag_bit,
                                     input logic [3:0] neg_dir, input logic [3:0] pos_dir);
    int dz;
    dz = cfg_deadzone;
    if (v < -dz) begin
      if (!stick_flags[flag_bit]) begin
        stick_flags[flag_bit] = 1'b1;
        start_hold(neg_dir);
        emit_cmd(neg_dir + CMD_DIR_OFFSET);
      end
    end else if (v > dz) begin
      if (!stick_flags[flag_bit + 1]) begin
        stick_flags[flag_bit + 1] = 1'b1;
        start_hold(pos_dir);
        emit_cmd(pos_dir + CMD_DIR_OFFSET);
      end
    end else begin
      stick_flags[flag_bit]     = 1'b0;
      stick_flags[flag_bit + 1] = 1'b0;
      if (held_dir == neg_dir || held_dir == pos_dir) held_dir = DIR_NONE;
    end
  endfunction

  function automatic void trigger_sample(input int v, input int which);
    int thr;
    thr = cfg_trig_thr;
    if (v > thr) begin
      if (!trig_flags[which]) begin
        trig_flags[which] = 1'b1;
        if (which == 0) begin
          trig_l_ticks = '0;
          emit_cmd(NAV_TRIG_LEFT);
        end else begin
          trig_r_ticks = '0;
          emit_cmd(NAV_TRIG_RIGHT);
        end
      end
    end else begin
      trig_flags[which] = 1'b0;
    end
  endfunction

  function automatic logic [7:0] next_trig(input logic [7:0] ticks, output logic fire);
    int t;
    t = ticks + 1;
    fire = (t >= cfg_trig_per);
    return fire ? 8'd0 : t[7:0];
  endfunction

  // Advance the model by one item; the commands land in step_cmds[0 +: step_n].
  function automatic void step_navigator(input nav_event_t ev);
    int   v;
    int   dz;
    int   t;
    logic fire;
    step_n = 0;
    v  = ev.value;
    dz = cfg_deadzone;
    if (!ev.active) begin
      held_dir   = DIR_NONE;
      trig_flags = '0;
      return;
    end
    case (ev.action)
      ACT_TICK: begin
        if (held_dir != DIR_NONE) begin
          t = rep_ticks + 1;
          if (t >= rep_int) begin
            rep_ticks = '0;
            if (int'(rep_int) >= int'(cfg_shortest) + int'(cfg_step)) rep_int = rep_int - cfg_step;
            else rep_int = cfg_shortest;
            emit_cmd(held_dir + CMD_DIR_OFFSET);
          end else begin
            rep_ticks = t[7:0];
          end
        end
        if (trig_flags[0]) begin
          trig_l_ticks = next_trig(trig_l_ticks, fire);
          if (fire) emit_cmd(NAV_TRIG_LEFT);
        end
        if (trig_flags[1]) begin
          trig_r_ticks = next_trig(trig_r_ticks, fire);
          if (fire) emit_cmd(NAV_TRIG_RIGHT);
        end
      end
      ACT_PRESS: begin
        if (ev.button < BTN_DPAD_UP) begin
          case (ev.button)
            BTN_BACK:  emit_cmd(NAV_SELECT);
            BTN_START: emit_cmd(NAV_START);
            default:   emit_cmd({1'b0, ev.button});
          endcase
        end else if (ev.button <= BTN_DPAD_RIGHT) begin
          start_hold(ev.button - BTN_DPAD_UP + 4'd1);
          emit_cmd(held_dir + CMD_DIR_OFFSET);
        end
      end
      ACT_RELEASE: begin
        if (ev.button >= BTN_DPAD_UP && ev.button <= BTN_DPAD_RIGHT &&
            held_dir == ev.button - BTN_DPAD_UP + 4'd1) held_dir = DIR_NONE;
      end
      default: begin
        case (ev.axis)
          AXIS_LX:   left_stick(v, FLAG_LX, DIR_LS_LEFT, DIR_LS_RIGHT);
          AXIS_LY:   left_stick(v, FLAG_LY, DIR_LS_UP, DIR_LS_DOWN);
          AXIS_LTRG: trigger_sample(v, 0);
          AXIS_RTRG: trigger_sample(v, 1);
          AXIS_RX: begin
            if (v < -dz) begin
              if (!stick_flags[FLAG_RX_NEG]) begin
                stick_flags[FLAG_RX_NEG] = 1'b1;
                emit_cmd(NAV_RS_LEFT);
              end
            end else if (v > dz) begin
              if (!stick_flags[FLAG_RX_POS]) begin
                stick_flags[FLAG_RX_POS] = 1'b1;
                emit_cmd(NAV_RS_RIGHT);
              end
            end else begin
              stick_flags[FLAG_RX_NEG] = 1'b0;
              stick_flags[FLAG_RX_POS] = 1'b0;
            end
          end
          AXIS_RY: begin
            if (v < -dz) emit_cmd(NAV_VOL_UP);
            else if (v > dz) emit_cmd(NAV_VOL_DOWN);
          end
          default: ;
        endcase
      end
    endcase
  endfunction

  function automatic nav_event_t make_event(input logic [1:0] act, input logic [3:0] btn,
                                            input logic [2:0] ax, input int val,
                                            input logic act_on);
    nav_event_t ev;
    ev.action = act;
    ev.button = btn;
    ev.axis   = ax;
    ev.value  = 16'(val);
    ev.active = act_on;
    return ev;
  endfunction

  function automatic int pick_value();
    int dz;
    int thr;
    dz  = cfg_deadzone;
    thr = cfg_trig_thr;
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return dz;
      3:       return -dz;
      4:       return dz + 1;
      5:       return -dz - 1;
      6:       return thr + int'($urandom_range(0, 1));
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic add_row(input logic [1:0] act, input logic [3:0] btn, input logic [2:0] ax,
                         input int val, input logic act_on, input row_mode_e mode,
                         input logic [4:0] cmd);
    nav_row_t row;
    row.ev        = make_event(act, btn, ax, val, act_on);
    row.mode      = mode;
    row.typed_cmd = cmd;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input nav_event_t ev, input row_mode_e mode = ROW_PREDICT,
                           input logic [4:0] typed_cmd = '0);
    int          gap;
    nav_result_t res;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= ev.action;
    button_i     <= ev.button;
    axis_i       <= ev.axis;
    axis_value_i <= ev.value;
    app_active_i <= ev.active;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    step_navigator(ev);
    case (mode)
      ROW_PREDICT: begin
        for (int i = 0; i < step_n; i++) begin
          res.command = step_cmds[i];
          res.last    = (i == step_n - 1);
          pending_cmds.push_back(res);
        end
      end
      ROW_ONE: begin
        res.command = typed_cmd;
        res.last    = 1'b1;
        pending_cmds.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_DEADZONE:  cfg_deadzone = data;
      REG_TRIG_THR:  cfg_trig_thr = data;
      REG_FIRST_INT: cfg_first    = data[7:0];
      REG_SHORT_INT: cfg_shortest = data[7:0];
      REG_INT_STEP:  cfg_step     = data[7:0];
      REG_TRIG_PER:  cfg_trig_per = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [14:0] dz, input logic [14:0] thr,
                                input logic [7:0] first, input logic [7:0] shortest,
                                input logic [7:0] step, input logic [7:0] per);
    wait_idle();
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_TRIG_THR, thr);
    write_reg(REG_FIRST_INT, {7'd0, first});
    write_reg(REG_SHORT_INT, {7'd0, shortest});
    write_reg(REG_INT_STEP, {7'd0, step});
    write_reg(REG_TRIG_PER, {7'd0, per});
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_noise();
    int val;
    val = $urandom_range(0, 1) ? pick_value() : $signed(16'($urandom));
    send_item(make_event(2'($urandom), 4'($urandom), 3'($urandom), val,
                         $urandom_range(0, 9) != 0));
  endtask

  // Press or deflect, tick a while with some noise mixed in, then let go.
  task automatic run_sequence();
    int         kind;
    int         ticks;
    int         dz;
    int         thr;
    int         mag;
    int         r;
    bit         neg;
    logic [3:0] btn;
    logic [2:0] ax;
    kind  = $urandom_range(0, 2);
    ticks = $urandom_range(1, 12);
    dz    = cfg_deadzone;
    thr   = cfg_trig_thr;
    neg   = $urandom_range(0, 1);
    btn   = BTN_DPAD_UP + 4'($urandom_range(0, 3));
    case (kind)
      0: send_item(make_event(ACT_PRESS, btn, 3'($urandom), $urandom, 1'b1));
      1: begin
        ax  = $urandom_range(0, 1) ? AXIS_LY : AXIS_LX;
        mag = dz + 1 + int'($urandom_range(0, 32767 - dz));
        send_item(make_event(ACT_AXIS, 4'($urandom), ax, neg ? -mag : mag, 1'b1));
      end
      default: begin
        ax  = $urandom_range(0, 1) ? AXIS_RTRG : AXIS_LTRG;
        mag = thr + 1 + int'($urandom_range(0, 32767 - thr));
        send_item(make_event(ACT_AXIS, 4'($urandom), ax, mag, 1'b1));
      end
    endcase
    repeat (ticks) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      send_item(make_event(ACT_TICK, 4'($urandom), 3'($urandom), $urandom, 1'b1));
    end
    case (kind)
      0: send_item(make_event(ACT_RELEASE, $urandom_range(0, 4) == 0 ? BTN_DPAD_DOWN : btn,
                              3'($urandom), $urandom, 1'b1));
      1: begin
        mag = $urandom_range(0, dz);
        send_item(make_event(ACT_AXIS, 4'($urandom), ax, neg ? -mag : mag, 1'b1));
      end
      default: begin
        r = $urandom_range(0, thr + 32768);
        send_item(make_event(ACT_AXIS, 4'($urandom), ax, thr - r, 1'b1));
      end
    endcase
  endtask

  // Check each command against the oldest expectation and pace out_ready_i.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected command %0d last %0b", command_o, last_o));
        end else begin
          rx_exp = pending_cmds.pop_front();
          if (command_o !== rx_exp.command)
            report_mismatch($sformatf("command %0d, want %0d", command_o, rx_exp.command));
          if (last_o !== rx_exp.last)
            report_mismatch($sformatf("last %0b on command %0d, want %0b",
                                      last_o, command_o, rx_exp.last));
          cmds_checked++;
        end
        rx_wait = rx_gaps ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (burst_served != burst_requests) begin
        burst_served++;
        rx_hold = RX_HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase_goal;
    bit paused;
    paused = 1'b0;
    add_row(ACT_PRESS, BTN_A, AXIS_LX, 0, 1'b1, ROW_ONE, NAV_A);
    add_row(ACT_PRESS, BTN_BACK, AXIS_LX, 0, 1'b1, ROW_ONE, NAV_SELECT);
    add_row(ACT_PRESS, BTN_START, AXIS_LX, 0, 1'b1, ROW_ONE, NAV_START);
    add_row(ACT_PRESS, BTN_RSHOULDER, AXIS_LX, 0, 1'b1, ROW_ONE, NAV_RSHOULDER);
    add_row(ACT_PRESS, BTN_RESERVED, AXIS_LX, 0, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_PRESS, BTN_DPAD_UP, AXIS_LX, 0, 1'b1, ROW_ONE, NAV_DPAD_UP);
    add_row(ACT_TICK, BTN_A, AXIS_LX, 0, 1'b1, ROW_PREDICT, NAV_A);
    add_row(ACT_RELEASE, BTN_DPAD_DOWN, AXIS_LX, 0, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_RELEASE, BTN_DPAD_UP, AXIS_LX, 0, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_AXIS, BTN_A, AXIS_LX, VAL_MIN, 1'b1, ROW_ONE, NAV_LS_LEFT);
    add_row(ACT_AXIS, BTN_A, AXIS_LX, VAL_MAX, 1'b1, ROW_ONE, NAV_LS_RIGHT);
    add_row(ACT_AXIS, BTN_A, AXIS_LX, 0, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_AXIS, BTN_A, AXIS_LY, VAL_MIN, 1'b1, ROW_ONE, NAV_LS_UP);
    add_row(ACT_AXIS, BTN_A, AXIS_LTRG, VAL_MAX, 1'b1, ROW_ONE, NAV_TRIG_LEFT);
    add_row(ACT_AXIS, BTN_A, AXIS_RTRG, VAL_MAX, 1'b1, ROW_ONE, NAV_TRIG_RIGHT);
    add_row(ACT_TICK, BTN_A, AXIS_LX, 0, 1'b1, ROW_PREDICT, NAV_A);
    add_row(ACT_AXIS, BTN_A, AXIS_RX, VAL_MIN, 1'b1, ROW_ONE, NAV_RS_LEFT);
    add_row(ACT_AXIS, BTN_A, AXIS_RX, VAL_MAX, 1'b1, ROW_ONE, NAV_RS_RIGHT);
    add_row(ACT_AXIS, BTN_A, AXIS_RY, VAL_MIN, 1'b1, ROW_ONE, NAV_VOL_UP);
    add_row(ACT_AXIS, BTN_A, AXIS_RY, VAL_MAX, 1'b1, ROW_ONE, NAV_VOL_DOWN);
    add_row(ACT_AXIS, BTN_A, AXIS_UNUSED, VAL_MAX, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_AXIS, BTN_A, AXIS_RTRG, VAL_MIN, 1'b1, ROW_NONE, NAV_A);
    add_row(ACT_PRESS, BTN_A, AXIS_LX, 0, 1'b0, ROW_NONE, NAV_A);
    add_row(ACT_AXIS, BTN_A, AXIS_LTRG, VAL_MAX, 1'b1, ROW_ONE, NAV_TRIG_LEFT);
    add_row(ACT_TICK, BTN_A, AXIS_LX, 0, 1'b1, ROW_PREDICT, NAV_A);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].ev, directed_rows[i].mode, directed_rows[i].typed_cmd);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       apply_settings(15'd0, 15'd0, 8'd1, 8'd1, 8'd0, 8'd1);
        1:       apply_settings(15'd32767, 15'd32767, 8'd255, 8'd255, 8'd255, 8'd255);
        2:       apply_settings(15'd1000, 15'd100, 8'd2, 8'd10, 8'd3, 8'd2);
        3:       apply_settings(15'd20000, 15'd30000, 8'd0, 8'd0, 8'd1, 8'd0);
        4:       apply_settings(15'd8000, 15'd16000, 8'd6, 8'd2, 8'd1, 8'd3);
        default: apply_settings(15'd12345, 15'd5000, 8'd10, 8'd3, 8'd255, 8'd4);
      endcase
      tx_gaps    = (ph % 2) == 1;
      rx_gaps    = (ph % 3) != 0;
      phase_goal = items_sent + PHASE_ITEMS;
      // stall the receiver while a tick can fire up to three commands
      if (ph == 0) burst_requests++;
      while (items_sent < phase_goal) begin
        if (ph == 2 && !paused && items_sent >= phase_goal - PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_noise();
        else run_sequence();
      end
    end

    wait_idle();
    $display("covered %0d event items under %0d register settings plus reset values, %0d commands checked",
             items_sent, settings_applied, cmds_checked);
    if (error_count == 0) begin
      $display("gamepad_auto_repeat_navigator_tb OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("gamepad_auto_repeat_navigator_tb NOT OK");
    end
    $finish;
  end

endmodule
